// ===== hw/rtl/u8v_pkg.sv =====
`default_nettype none
package u8v_pkg;

  // default depth of the queue between front and back (at least 2)
  localparam int QUEUE_DEPTH = 2;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MIN_LEN2 = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_LEN3 = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_LEN4 = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10ffff;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00d800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00dfff;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // byte class decided in the front
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_t;

  typedef struct packed {
    kind_t      kind;
    byte_cls_t  cls;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/u8v_front.sv =====
`default_nettype none
module u8v_front
  import u8v_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tuser,
  output logic            push_valid,
  input  wire logic       push_ready,
  output item_t           push_data
);

  logic  front_valid_r;
  item_t front_item_r;
  item_t front_item_nxt;
  byte_cls_t cls;

  always_comb begin
    if (in_tdata[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (in_tdata[7:6] == 2'b10) begin
      cls = CLS_CONT;
    end else if (in_tdata[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (in_tdata[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (in_tdata[7:3] == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
    front_item_nxt.kind      = kind_t'(in_tuser);
    front_item_nxt.cls       = cls;
    front_item_nxt.data_byte = in_tdata;
  end

  assign in_tready  = !front_valid_r || push_ready;
  assign push_valid = front_valid_r;
  assign push_data  = front_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      front_valid_r <= 1'b1;
    end else if (push_ready) begin
      front_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/u8v_queue.sv =====
`default_nettype none
module u8v_queue
  import u8v_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_data,
  output q_stat_t    stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/u8v_back.sv =====
`default_nettype none
module u8v_back
  import u8v_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire item_t pop_data,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [7:0] out_tdata
);

  logic [1:0]      pending_r, pending_nxt;
  logic [1:0]      seq_len_r, seq_len_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            err_r, err_nxt;
  logic            out_valid_r;
  logic            res_r;
  logic [CP_W-1:0] acc_shift;
  logic [CP_W-1:0] cp_min;
  logic            cp_bad;
  logic            take;
  logic            is_end;

  assign is_end    = (pop_data.kind == KIND_END);
  assign pop_ready = !is_end || !out_valid_r || out_tready;
  assign take      = pop_valid && pop_ready;

  assign acc_shift = {acc_r[CP_W-7:0], pop_data.data_byte[5:0]};

  always_comb begin
    case (seq_len_r)
      2'd1:    cp_min = CP_MIN_LEN2;
      2'd2:    cp_min = CP_MIN_LEN3;
      default: cp_min = CP_MIN_LEN4;
    endcase
    cp_bad = (acc_shift < cp_min) || (acc_shift > CP_MAX) ||
             ((acc_shift >= CP_SURR_LO) && (acc_shift <= CP_SURR_HI));
  end

  always_comb begin
    pending_nxt = pending_r;
    seq_len_nxt = seq_len_r;
    acc_nxt     = acc_r;
    err_nxt     = err_r;
    if (is_end) begin
      pending_nxt = '0;
      seq_len_nxt = '0;
      acc_nxt     = '0;
      err_nxt     = 1'b0;
    end else if (pending_r != 2'd0) begin
      if (pop_data.cls != CLS_CONT) begin
        err_nxt     = 1'b1;
        pending_nxt = '0;
        seq_len_nxt = '0;
        acc_nxt     = '0;
      end else if (pending_r == 2'd1) begin
        // last byte of the sequence
        if (cp_bad) begin
          err_nxt = 1'b1;
        end
        pending_nxt = '0;
        seq_len_nxt = '0;
        acc_nxt     = '0;
      end else begin
        pending_nxt = pending_r - 2'd1;
        acc_nxt     = acc_shift;
      end
    end else begin
      unique case (pop_data.cls)
        CLS_ASCII: ;
        CLS_LEAD2: begin
          pending_nxt = 2'd1;
          seq_len_nxt = 2'd1;
          acc_nxt     = CP_W'(pop_data.data_byte[4:0]);
        end
        CLS_LEAD3: begin
          pending_nxt = 2'd2;
          seq_len_nxt = 2'd2;
          acc_nxt     = CP_W'(pop_data.data_byte[3:0]);
        end
        CLS_LEAD4: begin
          pending_nxt = 2'd3;
          seq_len_nxt = 2'd3;
          acc_nxt     = CP_W'(pop_data.data_byte[2:0]);
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      seq_len_r   <= '0;
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pending_r <= pending_nxt;
        seq_len_r <= seq_len_nxt;
        acc_r     <= acc_nxt;
        err_r     <= err_nxt;
      end
      if (take && is_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_end) begin
      res_r <= !err_r && (pending_r == 2'd0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r};

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_stream_validator.sv =====
`default_nettype none
// path: an end-of-string item accepted on the input passes the front register, the queue
//   and the back state update before its verdict shows on out_*
// throughput: one item per cycle while no unread verdict on out_* holds the back
// only end-of-string items give a result; data bytes give none
// reset: synchronous active-low rst_n empties the front register, the queue and the
//   output register, and clears the decoder state and the sticky error flag
module utf8_stream_validator
  import u8v_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] kind (1 = end of string)
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] valid_res, [7:1] zero
);

  // front to queue
  logic    push_valid;
  logic    push_ready;
  item_t   push_data;
  // queue to back
  logic    pop_valid;
  logic    pop_ready;
  item_t   pop_data;
  q_stat_t q_stat;

  // front: registers the item and classifies the byte
  u8v_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // short queue so that an output stall does not reach the input at once
  u8v_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .stat       (q_stat)
  );

  // back: sequence decoder, sticky error flag and the output register
  u8v_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // back takes an item only when the queue holds one
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a new result follows the take of an end-of-string item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pop_valid && pop_ready && (pop_data.kind == KIND_END)))
    else $error("result without end item");

  // a full queue with a held front item stalls the input
  a_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && q_stat.full) |-> !in_tready)
    else $error("input accepted while front is blocked");

endmodule
`default_nettype wire

// ===== test/utf8_verdict_checker.sv =====
`timescale 1ns / 1ps
// watches both channels, decodes the accepted bytes on its own and checks every verdict
module utf8_verdict_checker
  import u8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] kind
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] valid_res, [7:1] zero
  output int         fail_count,
  output int         pending_verdicts,
  output int         verdicts_checked,
  output int         verdicts_good
);

  logic [1:0]      cont_left;
  logic [1:0]      seq_len;
  logic [CP_W-1:0] cp_acc;
  logic            err_sticky;
  logic            verdict_q[$];

  task automatic clear_seq();
    cont_left = 2'd0;
    seq_len   = 2'd0;
    cp_acc    = '0;
  endtask

  task automatic decode_item(input kind_t k, input logic [7:0] b);
    logic [CP_W-1:0] floor_cp;
    if (k == KIND_END) begin
      verdict_q.insert(verdict_q.size(), !err_sticky && (cont_left == 2'd0));
      clear_seq();
      err_sticky = 1'b0;
    end else if (cont_left == 2'd0) begin
      if (b[7]) begin
        if (b[7:5] == 3'b110) begin
          cont_left = 2'd1;
          cp_acc    = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          cont_left = 2'd2;
          cp_acc    = CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          cont_left = 2'd3;
          cp_acc    = CP_W'(b[2:0]);
        end else begin
          err_sticky = 1'b1;
        end
        seq_len = cont_left;
      end
    end else if (b[7:6] != 2'b10) begin
      // broken sequence is dropped, this byte is not taken as a lead
      err_sticky = 1'b1;
      clear_seq();
    end else begin
      cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (seq_len == 2'd1)      floor_cp = CP_MIN_LEN2;
        else if (seq_len == 2'd2) floor_cp = CP_MIN_LEN3;
        else                      floor_cp = CP_MIN_LEN4;
        if (cp_acc < floor_cp || cp_acc > CP_MAX ||
            (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI))
          err_sticky = 1'b1;
        clear_seq();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_seq();
      err_sticky = 1'b0;
      verdict_q.delete();
      fail_count       <= 0;
      verdicts_checked <= 0;
      verdicts_good    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict %0d, none expected", $time, out_tdata[0]);
          fail_count <= fail_count + 1;
        end else begin
          if (out_tdata !== {7'd0, verdict_q[0]}) begin
            $display("%0t: verdict mismatch: expected %0d, actual %0d (out_tdata %h)",
                     $time, verdict_q[0], out_tdata[0], out_tdata);
            fail_count <= fail_count + 1;
          end
          if (verdict_q[0]) verdicts_good <= verdicts_good + 1;
          verdicts_checked <= verdicts_checked + 1;
          void'(verdict_q.pop_front());
        end
      end
      if (in_tvalid && in_tready)
        decode_item(kind_t'(in_tuser), in_tdata);
    end
    pending_verdicts <= verdict_q.size();
  end

endmodule

// ===== test/tb_utf8_stream_validator.sv =====
`timescale 1ns / 1ps
module tb_utf8_stream_validator;
  import u8v_pkg::*;

  // stop point for the item count and hard cycle limit
  localparam int ITEM_TARGET = 440;
  localparam int CYCLE_LIMIT = 200000;

  // kinds of damage put into an otherwise well-formed string
  typedef enum int {
    FLAW_OVERLONG,
    FLAW_SURROGATE,
    FLAW_ABOVE_MAX,
    FLAW_BAD_CONT,
    FLAW_STRAY_CONT,
    FLAW_BAD_LEAD,
    FLAW_TRUNCATED
  } flaw_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tuser;   // [0] kind (1 = end of string)
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] valid_res, [7:1] zero

  logic       calm;       // high during the stretch with no idling on either side
  int         cycles;
  int         items_sent;
  int         fail_count;
  int         pending_verdicts;
  int         verdicts_checked;
  int         verdicts_good;
  logic [7:0] str_bytes[$];  // bytes of the string being built

  utf8_stream_validator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  utf8_verdict_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .fail_count       (fail_count),
    .pending_verdicts (pending_verdicts),
    .verdicts_checked (verdicts_checked),
    .verdicts_good    (verdicts_good)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side stalls at random, about 31 percent of the time, never while calm
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 31);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, pending_verdicts);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one item on the input channel; a gap may come first, valid stays high
  // straight into the next item when there is none
  task automatic send_item(input kind_t k, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 31) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    calm <= (items_sent >= 220 && items_sent < 320);
  endtask

  // the built string followed by its end marker, whose data byte is junk
  task automatic send_string();
    foreach (str_bytes[i]) send_item(KIND_DATA, str_bytes[i]);
    send_item(KIND_END, 8'($urandom));
  endtask

  // byte idx of the len-byte encoding of cp
  function automatic logic [7:0] enc_byte(input int len, input logic [CP_W-1:0] cp,
                                          input int idx);
    logic [CP_W-1:0] pay;
    pay = cp >> (6 * (len - 1 - idx));
    if (idx != 0) return {2'b10, pay[5:0]};
    case (len)
      1:       return {1'b0, pay[6:0]};
      2:       return {3'b110, pay[4:0]};
      3:       return {4'b1110, pay[3:0]};
      default: return {5'b11110, pay[2:0]};
    endcase
  endfunction

  // legal code point for a given length, now and then at the range edges
  function automatic logic [CP_W-1:0] pick_cp(input int len);
    logic [CP_W-1:0] lo, hi, cp;
    int unsigned     r;
    case (len)
      1:       begin lo = '0;          hi = 21'h00007f;    end
      2:       begin lo = CP_MIN_LEN2; hi = 21'h0007ff;    end
      3:       begin lo = CP_MIN_LEN3; hi = 21'h00ffff;    end
      default: begin lo = CP_MIN_LEN4; hi = CP_MAX;        end
    endcase
    r = $urandom_range(9);
    if (r == 0)      cp = lo;
    else if (r == 1) cp = hi;
    else             cp = CP_W'(lo + $urandom_range(hi - lo));
    // move surrogates up into 0xf800..0xffff
    if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h002000;
    return cp;
  endfunction

  // first keep bytes of the encoding go into the string
  task automatic put_char(input int len, input logic [CP_W-1:0] cp, input int keep);
    for (int i = 0; i < keep; i++) str_bytes.insert(str_bytes.size(), enc_byte(len, cp, i));
  endtask

  task automatic put_flaw(input flaw_t f);
    int         len;
    logic [7:0] b;
    len = $urandom_range(4, 2);
    case (f)
      FLAW_OVERLONG: begin
        if (len == 2)      put_char(2, CP_W'($urandom_range(CP_MIN_LEN2 - 1)), 2);
        else if (len == 3) put_char(3, CP_W'($urandom_range(CP_MIN_LEN3 - 1)), 3);
        else               put_char(4, CP_W'($urandom_range(CP_MIN_LEN4 - 1)), 4);
      end
      FLAW_SURROGATE:
        put_char(3, CP_W'(CP_SURR_LO + $urandom_range(CP_SURR_HI - CP_SURR_LO)), 3);
      FLAW_ABOVE_MAX:
        put_char(4, CP_W'(CP_MAX + 1 + $urandom_range(21'h1fffff - CP_MAX - 1)), 4);
      FLAW_BAD_CONT: begin
        put_char(len, pick_cp(len), $urandom_range(len - 1, 1));
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        str_bytes.insert(str_bytes.size(), b);
      end
      FLAW_STRAY_CONT: str_bytes.insert(str_bytes.size(), 8'h80 + 8'($urandom_range(63)));
      FLAW_BAD_LEAD:   str_bytes.insert(str_bytes.size(), 8'hf8 + 8'($urandom_range(7)));
      default:         put_char(len, pick_cp(len), $urandom_range(len - 1, 1));
    endcase
  endtask

  initial begin
    int    mode;
    int    nchar;
    int    flaw_at;
    int    len;
    flaw_t flaw;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tuser   = KIND_DATA;
    out_tready = 1'b0;
    calm       = 1'b0;
    cycles     = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings
    str_bytes.delete();                              // empty string
    send_string();
    str_bytes = '{8'h00, 8'h7f, 8'hc2, 8'h80};       // ascii extremes, smallest 2-byte
    send_string();
    str_bytes = '{8'hc0, 8'haf};                     // overlong from a c0 lead
    send_string();
    str_bytes = '{8'hed, 8'ha0, 8'h80};              // surrogate
    send_string();
    str_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};       // just above the top code point
    send_string();
    str_bytes = '{8'h80, 8'hff};                     // illegal leads
    send_string();
    str_bytes = '{8'he2, 8'h41};                     // bad continuation, ascii not re-read
    send_string();
    str_bytes = '{8'hf0, 8'h9f};                     // sequence left open at the end
    send_string();

    // random strings: mostly well formed, some damaged, some pure noise
    while (items_sent < ITEM_TARGET) begin
      mode  = $urandom_range(99);
      nchar = $urandom_range(8);
      str_bytes.delete();
      if (mode < 20) begin
        repeat ($urandom_range(12)) str_bytes.insert(str_bytes.size(), 8'($urandom));
      end else begin
        flaw    = flaw_t'($urandom_range(6));
        flaw_at = (mode < 70) ? -1 : $urandom_range(nchar);
        if (mode >= 70 && flaw == FLAW_TRUNCATED) flaw_at = nchar;
        for (int i = 0; i <= nchar; i++) begin
          if (i == flaw_at) put_flaw(flaw);
          if (i < nchar) begin
            len = $urandom_range(4, 1);
            put_char(len, pick_cp(len), len);
          end
        end
      end
      send_string();
    end
    in_tvalid <= 1'b0;

    // drain, then keep the clock running to catch any stray verdict
    @(posedge clk);
    while (pending_verdicts != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d items; %0d verdicts checked, %0d of them well-formed strings",
             items_sent, verdicts_checked, verdicts_good);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== utf8_stream_validator.f =====
hw/rtl/u8v_pkg.sv
hw/rtl/u8v_front.sv
hw/rtl/u8v_queue.sv
hw/rtl/u8v_back.sv
hw/rtl/utf8_stream_validator.sv
test/utf8_verdict_checker.sv
test/tb_utf8_stream_validator.sv
